@@ rtl/htf_pkg.sv @@
package htf_pkg;

	localparam int NUM_TAGS = 20;
	localparam int NUM_ENTS = 41;
	localparam int PAT_MAX = 13;

	localparam logic [2:0] FLAG_NONE       = 3'd0;
	localparam logic [2:0] FLAG_STYLE_ON   = 3'd1;
	localparam logic [2:0] FLAG_STYLE_OFF  = 3'd2;
	localparam logic [2:0] FLAG_PRE_ON     = 3'd3;
	localparam logic [2:0] FLAG_PRE_OFF    = 3'd4;
	localparam logic [2:0] FLAG_SCRIPT_ON  = 3'd5;
	localparam logic [2:0] FLAG_SCRIPT_OFF = 3'd6;

	typedef logic [PAT_MAX*8-1:0] pat_t;

	typedef struct packed {
		pat_t pat;
		logic [3:0] len;
		logic [7:0] rep;
		logic [2:0] flag;
	} tag_rule_t;

	typedef struct packed {
		pat_t pat;
		logic [3:0] len;
		logic [1:0] rlen;
		logic [23:0] rep;
	} ent_rule_t;

	// A pending output record: up to three bytes from one decision.
	typedef struct packed {
		logic [1:0] cnt;
		logic [23:0] bytes;
		logic last;
		logic doc_end;
	} emit_t;

	// Patterns are stored with the first character in the low byte.
	function automatic pat_t mk(input string s);
		pat_t p;
		p = '0;
		for (int i = 0; i < s.len(); i++) begin
			p[i*8 +: 8] = s[i];
		end
		return p;
	endfunction

	function automatic tag_rule_t tag_rule(input int i);
		tag_rule_t r;
		r = '0;
		case (i)
			0: r = '{mk("<P>"), 4'd3, 8'h0a, FLAG_NONE};
			1: r = '{mk("</P>"), 4'd4, 8'h0a, FLAG_NONE};
			2: r = '{mk("<HR>"), 4'd4, 8'h0a, FLAG_NONE};
			3: r = '{mk("<CENTER>"), 4'd8, 8'h0a, FLAG_NONE};
			4: r = '{mk("</CENTER>"), 4'd9, 8'h0a, FLAG_NONE};
			5: r = '{mk("</TITLE>"), 4'd8, 8'h0a, FLAG_NONE};
			6: r = '{mk("<STYLE"), 4'd6, 8'h00, FLAG_STYLE_ON};
			7: r = '{mk("</STYLE>"), 4'd8, 8'h00, FLAG_STYLE_OFF};
			8: r = '{mk("<PRE>"), 4'd5, 8'h00, FLAG_PRE_ON};
			9: r = '{mk("</PRE>"), 4'd6, 8'h00, FLAG_PRE_OFF};
			10: r = '{mk("<SCRIPT"), 4'd7, 8'h00, FLAG_SCRIPT_ON};
			11: r = '{mk("</SCRIPT>"), 4'd9, 8'h00, FLAG_SCRIPT_OFF};
			12: r = '{mk("<BLOCKQUOTE>"), 4'd12, 8'h22, FLAG_NONE};
			13: r = '{mk("</BLOCKQUOTE>"), 4'd13, 8'h22, FLAG_NONE};
			14: r = '{mk("<BR>"), 4'd4, 8'h0a, FLAG_NONE};
			15: r = '{mk("</BR>"), 4'd5, 8'h0a, FLAG_NONE};
			16: r = '{mk("<CITE>"), 4'd6, 8'h22, FLAG_NONE};
			17: r = '{mk("</CITE>"), 4'd7, 8'h22, FLAG_NONE};
			18: r = '{mk("<TD>"), 4'd4, 8'h09, FLAG_NONE};
			19: r = '{mk("</TD>"), 4'd5, 8'h09, FLAG_NONE};
			default: r = '0;
		endcase
		return r;
	endfunction

	function automatic ent_rule_t ent_q(input string s, input int n);
		ent_rule_t r;
		r = '0;
		r.pat = mk(s);
		r.len = 4'(n);
		r.rlen = 2'd1;
		r.rep = 24'h00003f;
		return r;
	endfunction

	function automatic ent_rule_t ent_rule(input int i);
		ent_rule_t r;
		r = '0;
		case (i)
			0: r = '{mk("&lt;"), 4'd4, 2'd1, 24'h00003c};
			1: r = '{mk("&gt;"), 4'd4, 2'd1, 24'h00003e};
			2: r = '{mk("&amp;"), 4'd5, 2'd1, 24'h000026};
			3: r = '{mk("&quot;"), 4'd6, 2'd1, 24'h000022};
			4: r = ent_q("&aacute;", 8);
			5: r = ent_q("&agrave;", 8);
			6: r = ent_q("&acirc;", 7);
			7: r = ent_q("&atilde;", 8);
			8: r = ent_q("&aring;", 7);
			9: r = ent_q("&auml;", 6);
			10: r = ent_q("&aelig;", 7);
			11: r = ent_q("&ccedil;", 8);
			12: r = ent_q("&eacute;", 8);
			13: r = ent_q("&egrave;", 8);
			14: r = ent_q("&ecirc;", 7);
			15: r = ent_q("&euml;", 6);
			16: r = ent_q("&iacute;", 8);
			17: r = ent_q("&igrave;", 8);
			18: r = ent_q("&icirc;", 7);
			19: r = ent_q("&iuml;", 6);
			20: r = ent_q("&eth;", 5);
			21: r = ent_q("&ntilde;", 8);
			22: r = ent_q("&oacute;", 8);
			23: r = ent_q("&ograve;", 8);
			24: r = ent_q("&ocirc;", 7);
			25: r = ent_q("&otilde;", 8);
			26: r = ent_q("&ouml;", 6);
			27: r = '{mk("&oslash;"), 4'd8, 2'd1, 24'h000030};
			28: r = ent_q("&uacute;", 8);
			29: r = ent_q("&ugrave;", 8);
			30: r = ent_q("&ucirc;", 7);
			31: r = ent_q("&uuml;", 6);
			32: r = '{mk("&yacute;"), 4'd8, 2'd1, 24'h000059};
			33: r = ent_q("&thorn;", 7);
			34: r = ent_q("&szlig;", 7);
			35: r = ent_q("&yuml;", 6);
			36: r = '{mk("&reg;"), 4'd5, 2'd3, 24'h297228};
			37: r = '{mk("&copy;"), 4'd6, 2'd3, 24'h296328};
			38: r = '{mk("&trade;"), 4'd7, 2'd2, 24'h006d74};
			39: r = '{mk("&nbsp;"), 4'd6, 2'd1, 24'h000020};
			40: r = '{mk("&middot;"), 4'd8, 2'd2, 24'h00a4a1};
			default: r = '0;
		endcase
		return r;
	endfunction

	function automatic logic [7:0] fold(input logic [7:0] c);
		return (c >= 8'h61 && c <= 8'h7a) ? c - 8'd32 : c;
	endfunction

endpackage

@@ rtl/htf_front.sv @@
module htf_front #(
	parameter int LOOKAHEAD = 16,
	parameter int MAX_DIGITS = 8
) (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_stall,
	input  logic [7:0] in_byte,
	input  logic in_last,
	output logic q_push,
	output htf_pkg::emit_t q_data,
	input  logic q_full
);
	import htf_pkg::*;

	localparam int FW = $clog2(LOOKAHEAD + 1);
	localparam int IW = $clog2(LOOKAHEAD);
	localparam int SW = 4;

	logic [7:0] win_q [LOOKAHEAD];
	logic [FW-1:0] fill_q;
	logic [SW-1:0] skip_q;
	logic tag_q, script_q, style_q, pre_q;
	logic drain_q;
	emit_t hold_q;
	logic hold_v_q;

	logic [LOOKAHEAD*8-1:0] wflat;
	logic decide, accept, dec_in, dec_dr, flush;
	logic [FW-1:0] fill_eff;
	emit_t rec;
	logic [SW-1:0] skip_n;
	logic tag_n, script_n, style_n, pre_n;
	logic [7:0] val;
	logic dig_go, dig_nz;
	int cnt;
	logic [7:0] b0, b1, dg;

	// The byte arriving on a decision cycle takes the last window slot.
	always_comb begin
		for (int i = 0; i < LOOKAHEAD; i++) begin
			wflat[i*8 +: 8] = (dec_in && i == LOOKAHEAD - 1) ? in_byte : win_q[i];
		end
	end

	assign in_stall = drain_q;
	assign accept = in_valid && !drain_q;
	// A decision happens when a byte fills the window, or on a drain cycle while bytes remain.
	assign dec_in = accept && !in_last && fill_q == FW'(LOOKAHEAD - 1);
	assign dec_dr = drain_q && fill_q != '0;
	assign flush = drain_q && fill_q == '0;
	assign decide = dec_in || dec_dr;
	assign fill_eff = dec_in ? FW'(LOOKAHEAD) : fill_q;
	assign b0 = wflat[7:0];
	assign b1 = wflat[15:8];

	always_comb begin
		tag_rule_t tr;
		ent_rule_t er;
		logic done, ok, hit;
		logic [3:0] used;
		tr = '0;
		er = '0;
		ok = 1'b0;
		rec = '0;
		skip_n = skip_q;
		tag_n = tag_q;
		script_n = script_q;
		style_n = style_q;
		pre_n = pre_q;
		done = 1'b0;
		used = 4'd1;
		val = '0;
		cnt = 0;
		dig_go = 1'b1;
		dig_nz = 1'b0;
		hit = 1'b0;
		dg = '0;
		if (skip_q != '0) begin
			skip_n = skip_q - 1'b1;
			done = 1'b1;
			used = 4'd0;
		end else if (!pre_q && (b0 == 8'h20 || b0 == 8'h09 || b0 == 8'h0d || b0 == 8'h0a)) begin
			done = 1'b1;
		end
		if (!done) begin
			for (int t = 0; t < NUM_TAGS; t++) begin
				tr = tag_rule(t);
				ok = !hit && (FW'(tr.len) <= fill_eff);
				for (int k = 0; k < PAT_MAX; k++) begin
					if (k < int'(tr.len) && fold(wflat[k*8 +: 8]) != tr.pat[k*8 +: 8]) begin
						ok = 1'b0;
					end
				end
				if (ok) begin
					hit = 1'b1;
					used = tr.len;
					unique case (tr.flag)
						FLAG_NONE: begin
							rec.cnt = 2'd1;
							rec.bytes = {16'h0, tr.rep};
						end
						FLAG_STYLE_ON: style_n = 1'b1;
						FLAG_STYLE_OFF: style_n = 1'b0;
						FLAG_PRE_ON: pre_n = 1'b1;
						FLAG_PRE_OFF: pre_n = 1'b0;
						FLAG_SCRIPT_ON: script_n = 1'b1;
						default: script_n = 1'b0;
					endcase
				end
			end
			done = hit;
		end
		if (!done) begin
			if (b0 == 8'h3c && fill_eff > FW'(1)) begin
				if ((b1 >= 8'h61 && b1 <= 8'h7a) || (b1 >= 8'h41 && b1 <= 8'h5a) ||
						b1 == 8'h21 || b1 == 8'h2f) begin
					tag_n = 1'b1;
				end
			end
			if (b0 == 8'h3e && tag_n) begin
				tag_n = 1'b0;
				done = 1'b1;
			end
		end
		if (!done && !tag_n) begin
			if (b0 == 8'h26) begin
				for (int e = 0; e < NUM_ENTS; e++) begin
					er = ent_rule(e);
					ok = !hit && (FW'(er.len) <= fill_eff);
					for (int k = 0; k < PAT_MAX; k++) begin
						if (k < int'(er.len) && fold(wflat[k*8 +: 8]) != fold(er.pat[k*8 +: 8])) begin
							ok = 1'b0;
						end
					end
					if (ok) begin
						hit = 1'b1;
						used = er.len;
						rec.cnt = er.rlen;
						rec.bytes = er.rep;
					end
				end
				if (hit) begin
					done = 1'b1;
				end else if (fill_eff > FW'(1) && b1 == 8'h23) begin
					for (int d = 0; d < MAX_DIGITS; d++) begin
						dg = wflat[(d+2)*8 +: 8];
						if (dig_go && (d + 2) < int'(fill_eff) && dg >= 8'h30 && dg <= 8'h39) begin
							val = val * 8'd10 + (dg - 8'h30);
							if (dg != 8'h30) begin
								dig_nz = 1'b1;
							end
							cnt = d + 1;
						end else begin
							dig_go = 1'b0;
						end
					end
					if (cnt > 0 && dig_nz) begin
						rec.cnt = 2'd1;
						rec.bytes = {16'h0, val};
						used = 4'(cnt + 2);
						done = 1'b1;
					end
				end
			end
			if (!done && !script_n && !style_n) begin
				rec.cnt = 2'd1;
				rec.bytes = {16'h0, b0};
			end
		end
		if (used != 4'd0) begin
			skip_n = SW'(used - 4'd1);
		end
		rec.last = !drain_q;
		rec.doc_end = 1'b0;
	end

	// During a drain the newest record is held back so that the closing flags land on it.
	always_comb begin
		q_push = 1'b0;
		q_data = rec;
		if (flush) begin
			q_push = 1'b1;
			if (hold_v_q) begin
				q_data = hold_q;
			end else begin
				q_data = '0;
			end
			q_data.last = 1'b1;
			q_data.doc_end = 1'b1;
		end else if (dec_dr) begin
			q_push = hold_v_q && (rec.cnt != 2'd0);
			q_data = hold_q;
		end else if (dec_in) begin
			q_push = rec.cnt != 2'd0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
			skip_q <= '0;
			tag_q <= 1'b0;
			script_q <= 1'b0;
			style_q <= 1'b0;
			pre_q <= 1'b0;
			drain_q <= 1'b0;
			hold_q <= '0;
			hold_v_q <= 1'b0;
		end else if (!q_full) begin
			if (decide) begin
				skip_q <= skip_n;
				tag_q <= tag_n;
				script_q <= script_n;
				style_q <= style_n;
				pre_q <= pre_n;
			end
			if (dec_dr && rec.cnt != 2'd0) begin
				hold_q <= rec;
				hold_v_q <= 1'b1;
			end
			if (accept) begin
				if (!dec_in) begin
					fill_q <= fill_q + 1'b1;
				end
				if (in_last) begin
					drain_q <= 1'b1;
				end
			end else if (dec_dr) begin
				fill_q <= fill_q - 1'b1;
			end else if (flush) begin
				drain_q <= 1'b0;
				skip_q <= '0;
				tag_q <= 1'b0;
				script_q <= 1'b0;
				style_q <= 1'b0;
				pre_q <= 1'b0;
				hold_v_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (!q_full) begin
			if (decide) begin
				for (int i = 0; i < LOOKAHEAD - 1; i++) begin
					win_q[i] <= wflat[(i+1)*8 +: 8];
				end
			end else if (accept) begin
				win_q[fill_q[IW-1:0]] <= in_byte;
			end
		end
	end

endmodule

@@ rtl/htf_queue.sv @@
module htf_queue #(
	parameter int DEPTH = 4
) (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  htf_pkg::emit_t wdata,
	output logic full,
	output logic empty,
	input  logic pop,
	output htf_pkg::emit_t rdata
);
	import htf_pkg::*;

	localparam int AW = $clog2(DEPTH);

	emit_t mem_q [DEPTH];
	logic [AW-1:0] wp_q, rp_q;
	logic [AW:0] cnt_q;

	assign full = cnt_q == (AW+1)'(DEPTH);
	assign empty = cnt_q == '0;
	assign rdata = mem_q[rp_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0;
			rp_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push && !full) begin
				wp_q <= wp_q + 1'b1;
			end
			if (pop && !empty) begin
				rp_q <= rp_q + 1'b1;
			end
			cnt_q <= cnt_q + (AW+1)'(push && !full) - (AW+1)'(pop && !empty);
		end
	end

	always_ff @(posedge clk) begin
		if (push && !full) begin
			mem_q[wp_q] <= wdata;
		end
	end

endmodule

@@ rtl/htf_back.sv @@
module htf_back (
	input  logic clk,
	input  logic arst_n,
	input  logic q_empty,
	input  htf_pkg::emit_t q_data,
	output logic q_pop,
	output logic out_valid,
	input  logic out_stall,
	output logic [7:0] out_byte,
	output logic has_byte,
	output logic run_last,
	output logic doc_end
);
	import htf_pkg::*;

	logic [1:0] idx_q;
	logic fire;
	logic final_b;

	assign out_valid = !q_empty;
	assign fire = out_valid && !out_stall;
	assign final_b = (q_data.cnt == 2'd0) || (idx_q == q_data.cnt - 2'd1);
	assign q_pop = fire && final_b;
	assign has_byte = q_data.cnt != 2'd0;
	assign out_byte = has_byte ? q_data.bytes[idx_q*8 +: 8] : 8'h00;
	assign run_last = final_b && q_data.last;
	assign doc_end = final_b && q_data.doc_end;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '0;
		end else if (fire) begin
			idx_q <= final_b ? 2'd0 : idx_q + 2'd1;
		end
	end

endmodule

@@ rtl/html_to_text_filter.sv @@
// Channel | Signals                                 | Direction
// input   | in_valid, in_stall, in_byte, in_last    | into the block
// output  | out_valid, out_stall, out_byte, has_byte, run_last, doc_end | out of the block
// One byte is taken per cycle; the byte that fills the window is decided on in that cycle.
// A last byte starts a drain that decides each pending byte and then closes the document,
// during which input stalls. Input also stalls while the four-entry queue is full.
// Entity results leave one byte per cycle while out_stall is low.
// Reset clears the window fill, skip count and mode flags.
module html_to_text_filter #(
	parameter int LOOKAHEAD = 16,
	parameter int MAX_DIGITS = 8
) (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_stall,
	input  logic [7:0] in_byte,
	input  logic in_last,
	output logic out_valid,
	input  logic out_stall,
	output logic [7:0] out_byte,
	output logic has_byte,
	output logic run_last,
	output logic doc_end
);
	import htf_pkg::*;

	logic push, full, empty, pop, f_stall;
	emit_t wdata, rdata;

	htf_front #(.LOOKAHEAD(LOOKAHEAD), .MAX_DIGITS(MAX_DIGITS)) u_front (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(f_stall),
		.in_byte(in_byte), .in_last(in_last), .q_push(push), .q_data(wdata),
		.q_full(full)
	);

	assign in_stall = f_stall || full;

	htf_queue #(.DEPTH(4)) u_queue (
		.clk(clk), .arst_n(arst_n), .push(push), .wdata(wdata), .full(full),
		.empty(empty), .pop(pop), .rdata(rdata)
	);

	htf_back u_back (
		.clk(clk), .arst_n(arst_n), .q_empty(empty), .q_data(rdata), .q_pop(pop),
		.out_valid(out_valid), .out_stall(out_stall), .out_byte(out_byte),
		.has_byte(has_byte), .run_last(run_last), .doc_end(doc_end)
	);

	a_doc_end_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && doc_end |-> run_last) else $error("doc_end without run_last");
	a_bare_marker: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !has_byte |-> out_byte == 8'h00) else $error("bare marker carries data");
	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		full |-> in_stall) else $error("input open while queue full");

endmodule

@@ verif/tb_html_to_text_filter.sv @@
module tb_html_to_text_filter;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int LOOKAHEAD = 16;
	localparam int MAX_DIGITS = 8;
	localparam int CYCLE_LIMIT = 400000;

	typedef struct packed {
		logic [7:0] out_byte;
		logic has_byte;
		logic run_last;
		logic doc_end;
	} text_rec_t;

	class text_scoreboard;
		text_rec_t pending[$];
		int mismatches;
		int checked;
		logic [7:0] win[LOOKAHEAD];
		int fill;
		int skip;
		bit in_tag, script_mode, style_mode, in_pre;
		text_rec_t step_out[$];

		function void clear_state();
			fill = 0;
			skip = 0;
			in_tag = 0;
			script_mode = 0;
			style_mode = 0;
			in_pre = 0;
		endfunction

		function new();
			mismatches = 0;
			checked = 0;
			clear_state();
		endfunction

		function bit pat_hit(logic [103:0] pat, int len);
			if (len > fill) return 0;
			for (int i = 0; i < len; i++)
				if (htf_pkg::fold(win[i]) != htf_pkg::fold(pat[i*8 +: 8])) return 0;
			return 1;
		endfunction

		function void push_byte(logic [7:0] b);
			text_rec_t r;
			r = '{b, 1'b1, 1'b0, 1'b0};
			step_out.push_back(r);
		endfunction

		function void shift_out();
			for (int i = 0; i < LOOKAHEAD - 1; i++) win[i] = win[i+1];
			fill--;
		endfunction

		function void decide();
			logic [7:0] b0, c;
			int used, cnt;
			longint unsigned val;
			htf_pkg::tag_rule_t tr;
			htf_pkg::ent_rule_t er;
			bit done;
			b0 = win[0];
			used = 1;
			done = 0;
			if (skip > 0) begin
				skip--;
				shift_out();
				return;
			end
			if (!in_pre && (b0 == 8'h20 || b0 == 8'h09 || b0 == 8'h0d || b0 == 8'h0a)) begin
				shift_out();
				return;
			end
			for (int i = 0; i < htf_pkg::NUM_TAGS && !done; i++) begin
				tr = htf_pkg::tag_rule(i);
				if (pat_hit(tr.pat, tr.len)) begin
					case (tr.flag)
						htf_pkg::FLAG_NONE: push_byte(tr.rep);
						htf_pkg::FLAG_STYLE_ON: style_mode = 1;
						htf_pkg::FLAG_STYLE_OFF: style_mode = 0;
						htf_pkg::FLAG_PRE_ON: in_pre = 1;
						htf_pkg::FLAG_PRE_OFF: in_pre = 0;
						htf_pkg::FLAG_SCRIPT_ON: script_mode = 1;
						default: script_mode = 0;
					endcase
					used = tr.len;
					done = 1;
				end
			end
			if (!done) begin
				if (b0 == "<" && fill > 1) begin
					c = win[1];
					if ((c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "!" || c == "/")
						in_tag = 1;
				end
				if (b0 == ">" && in_tag) begin
					in_tag = 0;
					done = 1;
				end
			end
			if (!done && !in_tag) begin
				if (b0 == "&") begin
					for (int i = 0; i < htf_pkg::NUM_ENTS && !done; i++) begin
						er = htf_pkg::ent_rule(i);
						if (pat_hit(er.pat, er.len)) begin
							for (int k = 0; k < er.rlen; k++) push_byte(er.rep[k*8 +: 8]);
							used = er.len;
							done = 1;
						end
					end
					if (!done && fill > 1 && win[1] == "#") begin
						cnt = 0;
						val = 0;
						while (cnt < MAX_DIGITS && 2 + cnt < fill &&
							win[2+cnt] >= "0" && win[2+cnt] <= "9") begin
							val = val * 10 + (win[2+cnt] - "0");
							cnt++;
						end
						if (cnt > 0 && val > 0) begin
							push_byte(val[7:0]);
							used = cnt + 2;
							done = 1;
						end
					end
				end
				if (!done && !script_mode && !style_mode) push_byte(b0);
			end
			skip = used - 1;
			shift_out();
		endfunction

		function void note_input(logic [7:0] b, logic last);
			text_rec_t r;
			step_out.delete();
			if (fill < LOOKAHEAD) begin
				win[fill] = b;
				fill++;
			end
			if (!last) begin
				if (fill >= LOOKAHEAD) decide();
			end else begin
				while (fill > 0) decide();
				if (step_out.size() == 0) step_out.push_back('0);
				r = step_out.pop_back();
				r.doc_end = 1;
				step_out.push_back(r);
				clear_state();
			end
			if (step_out.size() > 0) begin
				r = step_out.pop_back();
				r.run_last = 1;
				step_out.push_back(r);
			end
			foreach (step_out[i]) pending.push_back(step_out[i]);
		endfunction

		function void check_result(text_rec_t got);
			text_rec_t want;
			checked++;
			if (pending.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("unexpected transfer: %p", got);
				return;
			end
			want = pending.pop_front();
			if (got !== want) begin
				mismatches++;
				if (mismatches <= 10)
					$display("mismatch: expected byte=%h has=%b run=%b end=%b, got byte=%h has=%b run=%b end=%b",
						want.out_byte, want.has_byte, want.run_last, want.doc_end,
						got.out_byte, got.has_byte, got.run_last, got.doc_end);
			end
		endfunction
	endclass

	logic clk = 0;
	logic arst_n = 0;
	logic in_valid = 0;
	logic in_stall;
	logic [7:0] in_byte = 0;
	logic in_last = 0;
	logic out_valid;
	logic out_stall = 0;
	logic [7:0] out_byte;
	logic has_byte, run_last, doc_end;

	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	int cycles = 0;
	int docs = 0;
	text_scoreboard sb = new();
	logic [7:0] doc[$];

	html_to_text_filter #(.LOOKAHEAD(LOOKAHEAD), .MAX_DIGITS(MAX_DIGITS)) DUT (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
		.in_byte(in_byte), .in_last(in_last), .out_valid(out_valid), .out_stall(out_stall),
		.out_byte(out_byte), .has_byte(has_byte), .run_last(run_last), .doc_end(doc_end)
	);

	always begin
		#5 clk = 1;
		#5 clk = 0;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("tb_html_to_text_filter: FAIL");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			sb.check_result('{out_byte, has_byte, run_last, doc_end});
		out_stall <= ($urandom_range(99) < recv_stall_pct);
	end

	task automatic send_byte(logic [7:0] b, logic last);
		while (($urandom_range(99) < send_idle_pct)) begin
			in_valid <= 0;
			@(posedge clk);
		end
		in_valid <= 1;
		in_byte <= b;
		in_last <= last;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		sb.note_input(b, last);
	endtask

	task automatic send_doc();
		for (int i = 0; i < doc.size(); i++) send_byte(doc[i], i == doc.size() - 1);
		docs++;
		doc.delete();
	endtask

	task automatic add_str(string s);
		for (int i = 0; i < s.len(); i++) doc.push_back(s[i]);
	endtask

	task automatic add_random_piece();
		string toks[$] = '{"<p>", "</P>", "<hr>", "<Center>", "</center>", "</title>",
			"<style>", "</style>", "<pre>", "</pre>", "<script>", "</SCRIPT>",
			"<blockquote>", "</blockquote>", "<br>", "</br>", "<cite>", "</cite>",
			"<td>", "</td>", "&lt;", "&gt;", "&amp;", "&AMP;", "&quot;", "&eacute;",
			"&oslash;", "&Oslash;", "&yacute;", "&reg;", "&copy;", "&trade;", "&nbsp;",
			"&middot;", "&#65;", "&#0;", "&#300;", "&#999", "&#123456789012;", "&#",
			"<b>", "<!x>", "<x y>", "< a", "x y\n", "\t\r", "&bogus;", ">", "Text"};
		int k;
		k = $urandom_range(9);
		if (k < 7) add_str(toks[$urandom_range(toks.size() - 1)]);
		else doc.push_back(8'($urandom_range(255)));
	endtask

	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		add_str("<");
		send_doc();
		add_str("&#");
		send_doc();
		add_str("  ");
		send_doc();
		for (int ph = 0; ph < 4; ph++) begin
			send_idle_pct = (ph == 1 || ph == 3) ? ((ph == 3) ? 21 : 52) : 0;
			recv_stall_pct = (ph == 2 || ph == 3) ? ((ph == 3) ? 21 : 52) : 0;
			for (int d = 0; d < 2; d++) begin
				while (doc.size() < 18) add_random_piece();
				send_doc();
			end
		end
		in_valid <= 0;
		recv_stall_pct = 0;
		while (sb.pending.size() > 0) @(posedge clk);
		repeat (50) @(posedge clk);
		$display("Covered %0d documents with tags, entities, decimal references and modes,",
			docs);
		$display("%0d results checked under four idle and stall mixes.", sb.checked);
		if (sb.mismatches == 0 && sb.pending.size() == 0)
			$display("tb_html_to_text_filter: PASS");
		else
			$display("tb_html_to_text_filter: FAIL");
		$finish;
	end
endmodule

@@ filelist.f @@
rtl/htf_pkg.sv
rtl/htf_front.sv
rtl/htf_queue.sv
rtl/htf_back.sv
rtl/html_to_text_filter.sv
verif/tb_html_to_text_filter.sv
